FILE: rtl/core/aip_pkg.sv
// Shared types and constants for the ASCII integer parser.
package aip_pkg;

	localparam int VALUE_BITS     = 64;
	localparam int OFFSET_BITS    = 16;
	localparam int BASE_BITS      = 6;
	localparam int DIGIT_BITS     = 6;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 8;

	// offset counter holds one beyond the output maximum
	localparam logic [OFFSET_BITS:0] OFF_CAP = (OFFSET_BITS + 1)'(1) << OFFSET_BITS;
	localparam logic [OFFSET_BITS:0] OFF_MAX = OFF_CAP - (OFFSET_BITS + 1)'(1);

	localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SELECT = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNED_MODE = 8'd1;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_SPACE,
		PH_FIRST,
		PH_ZERO,
		PH_HEXFIRST,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       string_start;
	} char_item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]  value_bits;
		logic [OFFSET_BITS-1:0] end_offset;
	} result_item_t;

	// classified character, front to back
	typedef struct packed {
		logic                  string_start;
		logic                  is_space;
		logic                  is_plus;
		logic                  is_minus;
		logic                  is_zero;
		logic                  is_x;
		logic                  is_digit;
		logic [DIGIT_BITS-1:0] digit;
	} cls_item_t;

	typedef struct packed {
		logic [BASE_BITS-1:0] base_select;
		logic                 signed_mode;
	} cfg_t;

endpackage

FILE: rtl/core/aip_fifo.sv
// Small first-in first-out queue with count-based full and empty.
module aip_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    store_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = store_q[rd_ptr_q];

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

FILE: rtl/core/aip_front.sv
// Front end: classifies each character and queues it for the parser.
module aip_front import aip_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  char_item_t char_item,
	input  logic       push,
	output logic       full,
	output cls_item_t  cls_item,
	output logic       cls_empty,
	input  logic       cls_pop
);

	cls_item_t  cls_d;
	logic [7:0] c;
	logic [$bits(cls_item_t)-1:0] rd_bits;

	assign c = char_item.char_byte;

	always_comb begin
		cls_d              = '0;
		cls_d.string_start = char_item.string_start;
		cls_d.is_space     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		cls_d.is_plus      = (c == CH_PLUS);
		cls_d.is_minus     = (c == CH_MINUS);
		cls_d.is_zero      = (c == CH_ZERO);
		cls_d.is_x         = (c == CH_LOWER_X) || (c == CH_UPPER_X);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			cls_d.is_digit = 1'b1;
			cls_d.digit    = DIGIT_BITS'(c - CH_ZERO);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			cls_d.is_digit = 1'b1;
			cls_d.digit    = DIGIT_BITS'(c - CH_LOWER_A + 8'd10);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			cls_d.is_digit = 1'b1;
			cls_d.digit    = DIGIT_BITS'(c - CH_UPPER_A + 8'd10);
		end
	end

	aip_fifo #(
		.WIDTH($bits(cls_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cls_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(cls_d),
		.full   (full),
		.pop    (cls_pop),
		.rd_data(rd_bits),
		.empty  (cls_empty)
	);

	assign cls_item = cls_item_t'(rd_bits);

endmodule

FILE: rtl/core/aip_back.sv
// Back end: parse state machine, accumulator and result queue.
module aip_back import aip_pkg::*; #(
	parameter int RESULT_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  cls_item_t    cls_item,
	input  logic         cls_empty,
	output logic         cls_pop,
	output result_item_t result_item,
	output logic         empty,
	input  logic         pop
);

	phase_t                 phase_q, phase_d;
	logic [VALUE_BITS-1:0]  acc_q, acc_d;
	logic                   neg_q, neg_d;
	logic [BASE_BITS-1:0]   base_q, base_d;
	logic [OFFSET_BITS:0]   off_q, off_d;
	logic                   handled;
	logic                   emit;
	result_item_t           res_d;
	logic                   res_full;
	logic                   go;
	logic [$bits(result_item_t)-1:0] res_bits;

	function automatic logic digit_ok(input cls_item_t it, input logic [BASE_BITS-1:0] b);
		return it.is_digit && b >= BASE_MIN && b <= BASE_MAX && it.digit < b;
	endfunction

	function automatic logic [OFFSET_BITS:0] bump(input logic [OFFSET_BITS:0] o);
		return (o < OFF_CAP) ? o + (OFFSET_BITS + 1)'(1) : o;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] clamp(input logic [OFFSET_BITS:0] o);
		return (o > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0] : o[OFFSET_BITS-1:0];
	endfunction

	assign go      = !cls_empty && !res_full;
	assign cls_pop = go;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		base_d  = base_q;
		off_d   = off_q;
		handled = 1'b0;
		emit    = 1'b0;
		res_d   = '0;

		if (cls_item.string_start) begin
			phase_d = PH_SPACE;
			acc_d   = '0;
			neg_d   = 1'b0;
			off_d   = '0;
			base_d  = cfg.base_select;
		end

		// leading whitespace and optional sign
		if (phase_d == PH_SPACE) begin
			if (cls_item.is_space) begin
				off_d   = bump(off_d);
				handled = 1'b1;
			end else if (cls_item.is_plus) begin
				off_d   = bump(off_d);
				phase_d = PH_FIRST;
				handled = 1'b1;
			end else if (cls_item.is_minus && cfg.signed_mode) begin
				neg_d   = 1'b1;
				off_d   = bump(off_d);
				phase_d = PH_FIRST;
				handled = 1'b1;
			end else begin
				phase_d = PH_FIRST;
			end
		end

		// first significant character: base is read from base_select here
		if (!handled && phase_d == PH_FIRST) begin
			base_d  = cfg.base_select;
			handled = 1'b1;
			if ((base_d == BASE_AUTO || base_d == BASE_HEX) && cls_item.is_zero) begin
				acc_d   = '0;
				off_d   = bump(off_d);
				phase_d = PH_ZERO;
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_DEC;
				end
				if (digit_ok(cls_item, base_d)) begin
					acc_d   = VALUE_BITS'(cls_item.digit);
					off_d   = bump(off_d);
					phase_d = PH_DIGITS;
				end else begin
					emit    = 1'b1;
					phase_d = PH_DONE;
				end
			end
		end

		// after a leading zero: hex prefix, or octal default in auto mode
		if (!handled && phase_d == PH_ZERO) begin
			if (cls_item.is_x) begin
				base_d  = BASE_HEX;
				off_d   = bump(off_d);
				phase_d = PH_HEXFIRST;
				handled = 1'b1;
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_OCT;
				end
				phase_d = PH_DIGITS;
			end
		end

		// "0x" with no hex digit after it converts only the zero
		if (!handled && phase_d == PH_HEXFIRST) begin
			handled = 1'b1;
			if (digit_ok(cls_item, base_d)) begin
				acc_d   = VALUE_BITS'(cls_item.digit);
				off_d   = bump(off_d);
				phase_d = PH_DIGITS;
			end else begin
				emit             = 1'b1;
				res_d.end_offset = clamp(off_d - (OFFSET_BITS + 1)'(1));
				phase_d          = PH_DONE;
			end
		end

		if (!handled && phase_d == PH_DIGITS) begin
			if (digit_ok(cls_item, base_d)) begin
				acc_d = acc_q * VALUE_BITS'(base_d) + VALUE_BITS'(cls_item.digit);
				off_d = bump(off_d);
			end else begin
				emit             = 1'b1;
				res_d.value_bits = neg_d ? (VALUE_BITS'(0) - acc_d) : acc_d;
				res_d.end_offset = clamp(off_d);
				phase_d          = PH_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= BASE_DEC;
			off_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			off_q   <= off_d;
		end
	end

	aip_fifo #(
		.WIDTH($bits(result_item_t)),
		.DEPTH(RESULT_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go && emit),
		.wr_data(res_d),
		.full   (res_full),
		.pop    (pop),
		.rd_data(res_bits),
		.empty  (empty)
	);

	assign result_item = result_item_t'(res_bits);

endmodule

FILE: rtl/core/ascii_integer_parser.sv
// Top level of the streaming ASCII-to-integer parser.
//
// Usage: characters enter one per transaction on the input queue port
// (push/full, payload char_item). Set string_start on the first character
// of each string. Whitespace and one sign (minus in signed mode only) are
// skipped, the radix comes from base_select (0 takes it from a "0", "0x" or
// "0X" prefix) and digits are accumulated modulo 2^64. The first character
// that is not a digit of the radix, NUL included, yields one result
// transaction (value_bits and end_offset) on the output queue port
// (empty/pop); later characters are dropped until the next string_start.
// Throughput: one character per cycle while the result queue is not full,
// set by the single multiply-add of the accumulator (64 bits by a 6-bit
// radix) in the parser stage. Path to the output: the classify queue
// registers each character and the parser, working on the queue head,
// writes the result into the result queue once that queue has room.
// A stalled receiver fills the two-entry result queue and then the
// four-entry classify queue, after which full rises; nothing is dropped.
// Configuration: cfg_valid/cfg_ready always ready; index 0 is base_select,
// index 1 is signed_mode, others are ignored. Write only while idle.
// Reset: asynchronous arst_n; base_select 10, signed_mode 1, parser waits
// for a string start, both queues empty.
module ascii_integer_parser import aip_pkg::*; #(
	parameter int CLS_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  char_item_t                char_item,
	input  logic                      push,
	output logic                      full,
	output result_item_t              result_item,
	output logic                      empty,
	input  logic                      pop,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t      cfg_q;
	cls_item_t cls_item;
	logic      cls_empty;
	logic      cls_pop;

	// register file takes a write every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_select <= BASE_DEC;
			cfg_q.signed_mode <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_SELECT: begin
					cfg_q.base_select <= cfg_data[BASE_BITS-1:0];
				end
				REG_SIGNED_MODE: begin
					cfg_q.signed_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// classify and queue
	aip_front #(
		.QUEUE_DEPTH(CLS_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_item(char_item),
		.push     (push),
		.full     (full),
		.cls_item (cls_item),
		.cls_empty(cls_empty),
		.cls_pop  (cls_pop)
	);

	// parse, accumulate, queue results
	aip_back #(
		.RESULT_DEPTH(RES_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cls_item   (cls_item),
		.cls_empty  (cls_empty),
		.cls_pop    (cls_pop),
		.result_item(result_item),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

FILE: tb/sv/ascii_integer_parser_test.sv
// Self-checking testbench for the streaming ASCII integer parser.
`timescale 1ns / 100ps

module ascii_integer_parser_test;
	import aip_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 8;
	localparam int MAX_GAP       = 5;
	localparam int RANDOM_ITEMS  = 320;
	localparam int RANDOM_PHASES = 8;
	localparam int STALL_CYCLES  = 150;
	localparam int IDLE_SETTLE   = 8;   // classify queue plus parser stage, with margin
	localparam int DRAIN_CYCLES  = 10;
	localparam int REPORT_LIMIT  = 40;
	localparam int NO_DIGIT      = 99;
	localparam int LONG_DIGITS   = 40;

	localparam logic [BASE_BITS-1:0]      BASE_UNARY = 6'd1;
	localparam logic [BASE_BITS-1:0]      BASE_TOP   = 6'd63;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 8'hFF;
	localparam logic [7:0]                CH_NUL     = 8'h00;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	char_item_t                char_item = '0;
	logic                      push      = 1'b0;
	logic                      full;
	result_item_t              result_item;
	logic                      empty;
	logic                      pop       = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// register copies and parser state of the predictor
	logic [BASE_BITS-1:0]   base_reg   = BASE_DEC;
	logic                   signed_reg = 1'b1;
	phase_t                 parser_phase = PH_DONE;
	logic [VALUE_BITS-1:0]  accum      = '0;
	logic                   negative   = 1'b0;
	logic [BASE_BITS-1:0]   radix      = BASE_DEC;
	logic [OFFSET_BITS:0]   char_count = '0;

	result_item_t expected_values[$];
	logic [7:0]   text[$];

	int send_gap_max = MAX_GAP;
	int recv_gap_max = MAX_GAP;
	int recv_hold    = 0;
	int error_count     = 0;
	int chars_sent      = 0;
	int strings_sent    = 0;
	int results_checked = 0;
	int reg_writes      = 0;

	ascii_integer_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_item   (char_item),
		.push        (push),
		.full        (full),
		.result_item (result_item),
		.empty       (empty),
		.pop         (pop),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int digit_value(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			return int'(c - CH_LOWER_A) + 10;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			return int'(c - CH_UPPER_A) + 10;
		return NO_DIGIT;
	endfunction

	function automatic bit digit_ok(input int d, input logic [BASE_BITS-1:0] b);
		return b >= BASE_MIN && b <= BASE_MAX && d < int'(b);
	endfunction

	task automatic bump_offset();
		if (char_count < OFF_CAP)
			char_count = char_count + 1'b1;
	endtask

	task automatic queue_result(input logic [VALUE_BITS-1:0] v, input logic [OFFSET_BITS:0] off);
		result_item_t r;
		r.value_bits = v;
		r.end_offset = (off > OFF_MAX) ? OFF_MAX[OFFSET_BITS-1:0] : off[OFFSET_BITS-1:0];
		expected_values.push_back(r);
		parser_phase = PH_DONE;
	endtask

	// Advance the parser by one character; phases fall through as in strtol.
	task automatic parse_char(input char_item_t it);
		logic [7:0] c;
		int         d;
		bit         taken;
		c     = it.char_byte;
		d     = digit_value(c);
		taken = 1'b0;
		if (it.string_start) begin
			parser_phase = PH_SPACE;
			accum        = '0;
			negative     = 1'b0;
			char_count   = '0;
			radix        = base_reg;
		end
		if (parser_phase == PH_SPACE) begin
			if (is_blank(c)) begin
				bump_offset();
				taken = 1'b1;
			end else if (c == CH_PLUS) begin
				bump_offset();
				parser_phase = PH_FIRST;
				taken = 1'b1;
			end else if (c == CH_MINUS && signed_reg) begin
				negative = 1'b1;
				bump_offset();
				parser_phase = PH_FIRST;
				taken = 1'b1;
			end else begin
				parser_phase = PH_FIRST;
			end
		end
		if (!taken && parser_phase == PH_FIRST) begin
			radix = base_reg;
			if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
				accum = '0;
				bump_offset();
				parser_phase = PH_ZERO;
			end else begin
				if (radix == BASE_AUTO)
					radix = BASE_DEC;
				if (digit_ok(d, radix)) begin
					accum = 64'(d);
					bump_offset();
					parser_phase = PH_DIGITS;
				end else begin
					queue_result('0, '0);
				end
			end
			taken = 1'b1;
		end
		if (!taken && parser_phase == PH_ZERO) begin
			if (c == CH_LOWER_X || c == CH_UPPER_X) begin
				radix = BASE_HEX;
				bump_offset();
				parser_phase = PH_HEXFIRST;
				taken = 1'b1;
			end else begin
				if (radix == BASE_AUTO)
					radix = BASE_OCT;
				parser_phase = PH_DIGITS;
			end
		end
		if (!taken && parser_phase == PH_HEXFIRST) begin
			// "0x" with no hex digit after it: only the zero counts
			if (digit_ok(d, radix)) begin
				accum = 64'(d);
				bump_offset();
				parser_phase = PH_DIGITS;
			end else begin
				queue_result('0, char_count - 1'b1);
			end
			taken = 1'b1;
		end
		if (!taken && parser_phase == PH_DIGITS) begin
			if (digit_ok(d, radix)) begin
				accum = accum * 64'(radix) + 64'(d);   // wraps, no overflow check
				bump_offset();
			end else begin
				queue_result(negative ? (64'd0 - accum) : accum, char_count);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Drivers and checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// One input transaction; push is left high so a zero gap gives back-to-back items.
	task automatic send_char(input logic [7:0] c, input logic s);
		char_item_t it;
		int         gap;
		it.char_byte    = c;
		it.string_start = s;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_item = it;
		push      = 1'b1;
		do @(posedge clk); while (full);
		chars_sent++;
		parse_char(it);
	endtask

	task automatic send_text(input bit first_start);
		int k;
		if (first_start)
			strings_sent++;
		for (k = 0; k < text.size(); k++)
			send_char(text[k], first_start && k == 0);
	endtask

	task automatic load_text(input string s);
		int k;
		text.delete();
		for (k = 0; k < s.len(); k++)
			text.push_back(s[k]);
	endtask

	// Sender stops offering and waits for every outstanding result.
	task automatic drain_results();
		@(negedge clk);
		push = 1'b0;
		while (expected_values.size() != 0)
			@(posedge clk);
	endtask

	// Also covers characters that give no result and may still sit in the pipe.
	task automatic wait_idle();
		drain_results();
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		if (idx == REG_BASE_SELECT)
			base_reg = data[BASE_BITS-1:0];
		else if (idx == REG_SIGNED_MODE)
			signed_reg = data[0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Unused upper data bits are randomised; the block should mask them.
	task automatic set_config(input logic [BASE_BITS-1:0] b, input logic sgn);
		write_reg(REG_BASE_SELECT, {2'($urandom), b});
		write_reg(REG_SIGNED_MODE, {7'($urandom), sgn});
	endtask

	function automatic logic [7:0] digit_char(input int d);
		if (d < 10)
			return CH_ZERO + 8'(d);
		return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d - 10);
	endfunction

	// Well-formed number for the current settings: blanks, sign, prefix, digits, stop char.
	task automatic build_number_text();
		int eff, mode, ndig, k, d;
		text.delete();
		repeat ($urandom_range(0, 2))
			text.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE :
			               CH_TAB + 8'($urandom_range(0, CH_CR - CH_TAB)));
		case ($urandom_range(0, 3))
			0: text.push_back(CH_PLUS);
			1: text.push_back(CH_MINUS);
			default: ;
		endcase
		eff  = int'(base_reg);
		mode = $urandom_range(0, 2);
		if (base_reg == BASE_AUTO) begin
			case (mode)
				0: begin
					eff = int'(BASE_DEC);
					text.push_back(digit_char($urandom_range(1, 9)));
				end
				1: begin
					eff = int'(BASE_OCT);
					text.push_back(CH_ZERO);
				end
				default: begin
					eff = int'(BASE_HEX);
					text.push_back(CH_ZERO);
					text.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
				end
			endcase
		end else if (base_reg == BASE_HEX && mode != 0) begin
			text.push_back(CH_ZERO);
			text.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
		end
		// long runs can wrap the 64-bit accumulator
		ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
		for (k = 0; k < ndig; k++) begin
			d = (eff >= 2 && eff <= 36) ? $urandom_range(0, eff - 1) : $urandom_range(0, 35);
			text.push_back(digit_char(d));
		end
		text.push_back(($urandom_range(0, 1) == 0) ? CH_NUL : 8'($urandom));
	endtask

	task automatic check_result(input result_item_t got);
		result_item_t want;
		results_checked++;
		if (expected_values.size() == 0) begin
			report_mismatch($sformatf("result with none expected: value %h offset %0d",
			                          got.value_bits, got.end_offset));
		end else begin
			want = expected_values.pop_front();
			if (got.value_bits !== want.value_bits)
				report_mismatch($sformatf("value_bits %h, expected %h",
				                          got.value_bits, want.value_bits));
			if (got.end_offset !== want.end_offset)
				report_mismatch($sformatf("end_offset %0d, expected %0d",
				                          got.end_offset, want.end_offset));
		end
	endtask

	// Result side: random pop gaps, plus a long hold-off when a test asks for one.
	initial begin : result_side
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, recv_gap_max);
			@(negedge clk);
			if (recv_hold > 0) begin
				pop = 1'b0;
				repeat (recv_hold) @(negedge clk);
				recv_hold = 0;
			end
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			check_result(result_item);
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		// nothing has started a string yet, so these are dropped
		send_char(CH_UPPER_Z, 1'b0);
		send_char(8'hFF, 1'b0);
		// blank, minus, digits, NUL terminator
		load_text("\t-12");
		text.push_back(CH_NUL);
		send_text(1'b1);
		send_char(CH_ZERO + 8'd7, 1'b0);        // after the result: ignored
		// string abandoned by a new string_start, which has no digits
		load_text("+9");
		send_text(1'b1);
		load_text("x");
		send_text(1'b1);
		wait_idle();
		write_reg(REG_UNUSED, 8'hFF);
		set_config(BASE_AUTO, 1'b0);
		// hex prefix without digits
		load_text("0x");
		text.push_back(CH_NUL);
		send_text(1'b1);
		// minus is no sign in unsigned mode
		load_text("-5");
		send_text(1'b1);
		// leading zero selects octal, so '8' stops it
		load_text("0178");
		send_text(1'b1);
		wait_idle();
		set_config(BASE_MAX, 1'b1);
		load_text("zZ");
		text.push_back(8'hFF);
		send_text(1'b1);
		// invalid radices take no digit at all
		wait_idle();
		set_config(BASE_UNARY, 1'b1);
		load_text("1");
		send_text(1'b1);
		wait_idle();
		set_config(BASE_TOP, 1'b0);
		load_text("0");
		send_text(1'b1);
	endtask

	task automatic test_random_strings();
		int                   p, got, sel, keep, n;
		logic [BASE_BITS-1:0] b;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: b = BASE_AUTO;
				1: b = BASE_HEX;
				2: b = BASE_MAX;
				3: b = BASE_MIN;
				4: b = BASE_DEC;
				5: b = BASE_OCT;
				default: b = ($urandom_range(0, 9) == 0) ? 6'($urandom)
				                                         : 6'($urandom_range(2, 36));
			endcase
			set_config(b, (p % 2 == 0) ? 1'b1 : 1'b0);
			// every fourth phase runs flat out on both sides
			send_gap_max = (p % 4 == 3) ? 0 : MAX_GAP;
			recv_gap_max = (p % 4 == 3) ? 0 : MAX_GAP;
			got = 0;
			while (got < RANDOM_ITEMS / RANDOM_PHASES) begin
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					// noise
					text.delete();
					n = $urandom_range(1, 6);
					repeat (n) text.push_back(8'($urandom));
					got += text.size();
					send_text(1'($urandom_range(0, 1)));
				end else begin
					build_number_text();
					// broken string: cut short, the next start abandons it
					if (sel == 1 && text.size() > 1) begin
						keep = $urandom_range(1, text.size() - 1);
						while (text.size() > keep)
							text.delete(text.size() - 1);
					end
					got += text.size();
					send_text(1'b1);
				end
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 2)) send_char(8'($urandom), 1'b0);
			end
		end
		send_gap_max = MAX_GAP;
		recv_gap_max = MAX_GAP;
	endtask

	// Receiver holds off while short strings keep coming: result queue, then
	// classify queue fill and full must stall the sender without loss.
	task automatic test_full_stall();
		int k;
		wait_idle();
		set_config(BASE_DEC, 1'b1);
		send_gap_max = 0;
		recv_gap_max = 0;
		recv_hold    = STALL_CYCLES;
		for (k = 0; k < 40; k++) begin
			text.delete();
			if ($urandom_range(0, 1))
				text.push_back(CH_MINUS);
			repeat ($urandom_range(1, 2)) text.push_back(digit_char($urandom_range(0, 9)));
			text.push_back(CH_NUL);
			send_text(1'b1);
		end
		// sender pauses until the last result has gone, then resumes
		drain_results();
		send_gap_max = MAX_GAP;
		recv_gap_max = MAX_GAP;
		for (k = 0; k < 10; k++) begin
			build_number_text();
			send_text(1'b1);
		end
	endtask

	// Long blank run before a bare hex prefix, and a digit run long enough to
	// wrap the accumulator many times.
	task automatic test_long_strings();
		int n;
		wait_idle();
		set_config(BASE_HEX, 1'b1);
		send_gap_max = 0;
		recv_gap_max = 0;
		text.delete();
		n = $urandom_range(20, 40);
		repeat (n) text.push_back(CH_SPACE);
		text.push_back(CH_ZERO);
		text.push_back(CH_LOWER_X);
		text.push_back(CH_NUL);
		send_text(1'b1);
		wait_idle();
		set_config(BASE_DEC, 1'b0);
		text.delete();
		repeat (LONG_DIGITS) text.push_back(digit_char($urandom_range(0, 9)));
		text.push_back(CH_NUL);
		send_text(1'b1);
		send_gap_max = MAX_GAP;
		recv_gap_max = MAX_GAP;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_strings();
		test_full_stall();
		test_long_strings();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d characters in %0d strings, %0d results, %0d register writes,",
		         chars_sent, strings_sent, results_checked, reg_writes);
		$display("across all radix settings, both sign modes, a full stall and long strings.");
		if (error_count == 0)
			$display("** ascii_integer_parser: PASSED **");
		else
			$display("** ascii_integer_parser: FAILED **");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#1_000_000;
		$display("Timeout with %0d results still outstanding", expected_values.size());
		$display("** ascii_integer_parser: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/aip_pkg.sv
rtl/core/aip_fifo.sv
rtl/core/aip_front.sv
rtl/core/aip_back.sv
rtl/core/ascii_integer_parser.sv
tb/sv/ascii_integer_parser_test.sv
